/* hdl/esr_pkg.sv */
package esr_pkg;

    localparam int LOG_IN_W    = 64;
    localparam int MANT_W      = 32;
    localparam int LOG_INT_W   = 6;
    localparam int LOG_FRAC    = 24;
    localparam int LOG_W       = LOG_INT_W + LOG_FRAC;
    localparam int FRAC_IDX_W  = 5;
    localparam int NORM_STEP   = 8;

    localparam int K_W         = 26;
    localparam logic [K_W-1:0] DB_SCALE_Q16 = 26'd50504453;
    localparam int PROD_W      = LOG_W + K_W;
    localparam int ROUND_SHIFT = 40;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);

    localparam int ESR_W       = 17;
    localparam logic [ESR_W-1:0] ESR_LIMIT = 17'd50000;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;

    typedef struct packed {
        logic                start;
        logic [LOG_IN_W-1:0] x;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] result;
    } t_log_rsp;

    typedef struct packed {
        logic signed [ESR_W-1:0] esr_db;
        logic                    ref_silent;
    } t_result;

endpackage

/* hdl/error_to_signal_ratio_db.sv */
// Error-to-signal ratio meter.
// Input queue side: present a reference/estimate sample pair with last on
// push; the transaction completes on a clock edge with push high and full low.
// Pairs stream in at one per cycle while full is low. Each pair adds its
// squared error and squared reference into two saturating sums; the pair
// marked last closes the measurement and clears both sums.
// Output queue side: one result per measurement, o_esr_db in 1/256 dB with
// o_ref_silent; the result stays on the ports while empty is low and leaves
// on an edge with pop high and empty low.
// From the last pair to its result, a measurement passes a three-stage
// square-and-add pipeline, a hop through the queue, then two log2 runs on one
// shared unit (each normalizes, then squares once per fraction bit), a
// multiply and a round; a silent reference skips the logs, multiply and round.
// The back end works on one measurement at a time; up to four closed
// measurements wait between the two sides, after which full rises.
// A stalled receiver holds the result register; work behind it continues
// until the queue fills. Synchronous reset clears both sums, the queue and
// the output (empty high).
module error_to_signal_ratio_db #(
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_BITS    = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [SAMPLE_BITS-1:0]          i_ref_sample,
    input  logic [SAMPLE_BITS-1:0]          i_est_sample,
    input  logic                            i_last,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [esr_pkg::ESR_W-1:0] o_esr_db,
    output logic                            o_ref_silent
);

    logic                    w_snap_valid;
    logic [ACC_BITS-1:0]     w_snap_err;
    logic [ACC_BITS-1:0]     w_snap_ref;
    logic                    w_q_valid;
    logic [2*ACC_BITS-1:0]   w_q_data;
    logic                    w_q_pop;
    esr_pkg::t_log_req       w_log_req;
    esr_pkg::t_log_rsp       w_log_rsp;
    logic                    w_out_valid;
    esr_pkg::t_result        w_result;

    esr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_ref_sample (i_ref_sample),
        .i_est_sample (i_est_sample),
        .i_last       (i_last),
        .o_full       (full),
        .o_snap_valid (w_snap_valid),
        .o_snap_err   (w_snap_err),
        .o_snap_ref   (w_snap_ref),
        .i_release    (w_q_pop)
    );

    esr_queue #(
        .WIDTH (2 * ACC_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_snap_valid),
        .i_data  ({w_snap_err, w_snap_ref}),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    esr_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_q_valid),
        .i_snap_err   (w_q_data[2*ACC_BITS-1:ACC_BITS]),
        .i_snap_ref   (w_q_data[ACC_BITS-1:0]),
        .o_snap_pop   (w_q_pop),
        .o_log_req    (w_log_req),
        .i_log_rsp    (w_log_rsp),
        .i_pop        (pop),
        .o_valid      (w_out_valid),
        .o_result     (w_result)
    );

    esr_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_log_req),
        .o_rsp   (w_log_rsp)
    );

    assign empty        = ~w_out_valid;
    assign o_esr_db     = w_result.esr_db;
    assign o_ref_silent = w_result.ref_silent;

endmodule

/* hdl/esr_log2.sv */
module esr_log2 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esr_pkg::t_log_req   i_req,
    output esr_pkg::t_log_rsp   o_rsp
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQR
    } t_state;

    t_state                                  r_state;
    logic [esr_pkg::LOG_IN_W-1:0]            r_x;
    logic [esr_pkg::LOG_INT_W-1:0]           r_p;
    logic [esr_pkg::MANT_W-1:0]              r_m;
    logic [esr_pkg::LOG_FRAC-1:0]            r_frac;
    logic [esr_pkg::FRAC_IDX_W-1:0]          r_i;
    logic                                    r_done;

    logic [2*esr_pkg::MANT_W-1:0]            w_sq;
    logic [esr_pkg::MANT_W:0]                w_t;

    assign w_sq = r_m * r_m;
    assign w_t  = w_sq[2*esr_pkg::MANT_W-1:esr_pkg::MANT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_p     <= esr_pkg::LOG_INT_W'(esr_pkg::LOG_IN_W - 1);
                        r_frac  <= '0;
                        r_state <= L_NORM;
                    end
                end
                L_NORM: begin
                    r_done <= 1'b0;
                    if (r_x[esr_pkg::LOG_IN_W-1]) begin
                        r_m     <= r_x[esr_pkg::LOG_IN_W-1 -: esr_pkg::MANT_W];
                        r_i     <= esr_pkg::FRAC_IDX_W'(esr_pkg::LOG_FRAC - 1);
                        r_state <= L_SQR;
                    end else if (r_x[esr_pkg::LOG_IN_W-1 -: esr_pkg::NORM_STEP] == '0) begin
                        r_x <= r_x << esr_pkg::NORM_STEP;
                        r_p <= r_p - esr_pkg::LOG_INT_W'(esr_pkg::NORM_STEP);
                    end else begin
                        r_x <= r_x << 1;
                        r_p <= r_p - esr_pkg::LOG_INT_W'(1);
                    end
                end
                L_SQR: begin
                    r_done <= (r_i == '0);
                    if (w_t[esr_pkg::MANT_W]) begin
                        r_m         <= w_t[esr_pkg::MANT_W:1];
                        r_frac[r_i] <= 1'b1;
                    end else begin
                        r_m <= w_t[esr_pkg::MANT_W-1:0];
                    end
                    if (r_i == '0) begin
                        r_state <= L_IDLE;
                    end else begin
                        r_i <= r_i - esr_pkg::FRAC_IDX_W'(1);
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = {r_p, r_frac};

endmodule

/* hdl/esr_front.sv */
module esr_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_BITS    = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [SAMPLE_BITS-1:0] i_ref_sample,
    input  logic [SAMPLE_BITS-1:0] i_est_sample,
    input  logic                   i_last,
    output logic                   o_full,
    output logic                   o_snap_valid,
    output logic [ACC_BITS-1:0]    o_snap_err,
    output logic [ACC_BITS-1:0]    o_snap_ref,
    input  logic                   i_release
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int ESQ_W  = 2 * DIFF_W;
    localparam int RSQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W  = ((ESQ_W > ACC_BITS) ? ESQ_W : ACC_BITS) + 1;
    localparam int RESV_W = $clog2(esr_pkg::Q_DEPTH + 1);

    logic                    w_accept;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]       w_dmag;
    logic [SAMPLE_BITS-1:0]  w_rmag;
    logic [SUM_W-1:0]        w_esum;
    logic [SUM_W-1:0]        w_rsum;
    logic [ACC_BITS-1:0]     w_err_next;
    logic [ACC_BITS-1:0]     w_ref_next;
    logic [RESV_W-1:0]       n_resv;

    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic [DIFF_W-1:0]       r_s1_dmag;
    logic [SAMPLE_BITS-1:0]  r_s1_rmag;
    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic [ESQ_W-1:0]        r_s2_esq;
    logic [RSQ_W-1:0]        r_s2_rsq;
    logic [ACC_BITS-1:0]     r_err_acc;
    logic [ACC_BITS-1:0]     r_ref_acc;
    logic                    r_snap_valid;
    logic [ACC_BITS-1:0]     r_snap_err;
    logic [ACC_BITS-1:0]     r_snap_ref;
    logic [RESV_W-1:0]       r_resv;

    assign w_accept = i_push & ~o_full;

    assign w_diff = $signed({i_ref_sample[SAMPLE_BITS-1], i_ref_sample})
                  - $signed({i_est_sample[SAMPLE_BITS-1], i_est_sample});
    assign w_dmag = w_diff[DIFF_W-1] ? (~w_diff + 1'b1) : w_diff;
    assign w_rmag = i_ref_sample[SAMPLE_BITS-1] ? (~i_ref_sample + 1'b1) : i_ref_sample;

    assign w_esum     = SUM_W'(r_err_acc) + SUM_W'(r_s2_esq);
    assign w_rsum     = SUM_W'(r_ref_acc) + SUM_W'(r_s2_rsq);
    assign w_err_next = (|w_esum[SUM_W-1:ACC_BITS]) ? '1 : w_esum[ACC_BITS-1:0];
    assign w_ref_next = (|w_rsum[SUM_W-1:ACC_BITS]) ? '1 : w_rsum[ACC_BITS-1:0];

    // count measurements between acceptance and leaving the queue
    assign n_resv = r_resv + RESV_W'(w_accept & i_last) - RESV_W'(i_release);
    assign o_full = (r_resv == RESV_W'(esr_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_err_acc    <= '0;
            r_ref_acc    <= '0;
            r_resv       <= '0;
        end else begin
            r_resv     <= n_resv;
            r_s1_valid <= w_accept;
            r_s1_last  <= i_last;
            r_s1_dmag  <= w_dmag;
            r_s1_rmag  <= w_rmag;

            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
            r_s2_esq   <= r_s1_dmag * r_s1_dmag;
            r_s2_rsq   <= r_s1_rmag * r_s1_rmag;

            r_snap_valid <= r_s2_valid & r_s2_last;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_snap_err   <= w_err_next;
                    r_snap_ref   <= w_ref_next;
                    r_err_acc    <= '0;
                    r_ref_acc    <= '0;
                end else begin
                    r_err_acc <= w_err_next;
                    r_ref_acc <= w_ref_next;
                end
            end
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap_err   = r_snap_err;
    assign o_snap_ref   = r_snap_ref;

endmodule

/* hdl/esr_queue.sv */
module esr_queue #(
    parameter int WIDTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    logic [WIDTH-1:0]              r_mem [esr_pkg::Q_DEPTH];
    logic [esr_pkg::Q_PTR_W-1:0]   r_wr;
    logic [esr_pkg::Q_PTR_W-1:0]   r_rd;
    logic [esr_pkg::Q_PTR_W:0]     r_count;
    logic                          w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (esr_pkg::Q_PTR_W + 1)'(i_push)
                               - (esr_pkg::Q_PTR_W + 1)'(w_pop);
        end
    end

endmodule

/* hdl/esr_back.sv */
module esr_back #(
    parameter int ACC_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_snap_valid,
    input  logic [ACC_BITS-1:0]   i_snap_err,
    input  logic [ACC_BITS-1:0]   i_snap_ref,
    output logic                  o_snap_pop,
    output esr_pkg::t_log_req     o_log_req,
    input  esr_pkg::t_log_rsp     i_log_rsp,
    input  logic                  i_pop,
    output logic                  o_valid,
    output esr_pkg::t_result      o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG_E,
        S_LOG_R,
        S_MUL,
        S_RND,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [ACC_BITS-1:0]             r_ref;
    logic [esr_pkg::LOG_W-1:0]       r_le;
    logic [esr_pkg::LOG_W-1:0]       r_diff;
    logic                            r_neg;
    logic [esr_pkg::PROD_W-1:0]      r_prod;
    esr_pkg::t_result                r_res;
    esr_pkg::t_result                r_out;
    logic                            r_out_valid;
    esr_pkg::t_log_req               r_log_req;

    logic [ACC_BITS-1:0]             w_err_floor;
    logic [esr_pkg::LOG_W-1:0]       w_lr;
    logic                            w_neg;
    logic [esr_pkg::LOG_W-1:0]       w_diff;
    logic [esr_pkg::PROD_W:0]        w_rnd;
    logic [esr_pkg::ESR_W-1:0]       w_mag;
    logic [esr_pkg::ESR_W-1:0]       w_mag_sat;
    logic [esr_pkg::ESR_W-1:0]       w_esr;
    logic                            w_start;
    logic                            w_load;

    assign w_err_floor = (i_snap_err == '0) ? ACC_BITS'(1) : i_snap_err;
    assign w_lr        = i_log_rsp.result;
    assign w_neg       = (r_le < w_lr);
    assign w_diff      = w_neg ? (w_lr - r_le) : (r_le - w_lr);
    assign w_rnd       = (esr_pkg::PROD_W + 1)'(r_prod) + esr_pkg::ROUND_HALF;
    assign w_mag       = w_rnd[esr_pkg::PROD_W -: esr_pkg::ESR_W];
    assign w_mag_sat   = (w_mag > esr_pkg::ESR_LIMIT) ? esr_pkg::ESR_LIMIT : w_mag;
    assign w_esr       = r_neg ? (~w_mag_sat + 1'b1) : w_mag_sat;

    assign w_start = ((r_state == S_IDLE) && i_snap_valid && (i_snap_ref != '0))
                  || ((r_state == S_LOG_E) && i_log_rsp.done);
    assign w_load  = (r_state == S_OUT) && (!r_out_valid || i_pop);

    assign o_snap_pop  = (r_state == S_IDLE) && i_snap_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_log_req.start <= 1'b0;
        end else begin
            r_log_req.start <= w_start;
            if (w_load) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_snap_valid) begin
                        r_ref <= i_snap_ref;
                        if (i_snap_ref == '0) begin
                            r_res.esr_db     <= '0;
                            r_res.ref_silent <= 1'b1;
                            r_state          <= S_OUT;
                        end else begin
                            r_log_req.x     <= esr_pkg::LOG_IN_W'(w_err_floor);
                            r_state         <= S_LOG_E;
                        end
                    end
                end
                S_LOG_E: begin
                    if (i_log_rsp.done) begin
                        r_le            <= i_log_rsp.result;
                        r_log_req.x     <= esr_pkg::LOG_IN_W'(r_ref);
                        r_state         <= S_LOG_R;
                    end
                end
                S_LOG_R: begin
                    if (i_log_rsp.done) begin
                        r_diff  <= w_diff;
                        r_neg   <= w_neg;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_diff * esr_pkg::DB_SCALE_Q16;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_res.esr_db     <= w_esr;
                    r_res.ref_silent <= 1'b0;
                    r_state          <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_log_req = r_log_req;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

endmodule

/* hdl/esr_checker.sv */
module esr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic signed [esr_pkg::ESR_W-1:0] o_esr_db,
    input logic                             o_ref_silent
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_esr_db) && $stable(o_ref_silent)))
        else $error("stalled result changed or vanished");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_ref_silent) |-> (o_esr_db == '0))
        else $error("silent reference with nonzero ratio");

    a_db_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_esr_db <= $signed(esr_pkg::ESR_LIMIT)
                    && o_esr_db >= -$signed(esr_pkg::ESR_LIMIT)))
        else $error("ratio outside saturation limit");

endmodule

bind error_to_signal_ratio_db esr_checker u_esr_checker (.*);
